### hw/rtl/paeu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paeu_pkg: shared types and codes of the execute unit
// Operation codes, flag and error codes, channel payload types.
// ----------------------------------------------------------------------------
package paeu_pkg;

	typedef enum logic [4:0] {
		K_NONE     = 5'd0,
		K_STORAGE  = 5'd1,
		K_CONST    = 5'd2,
		K_ADD_M    = 5'd3,
		K_ADD_R    = 5'd4,
		K_SUB_M    = 5'd5,
		K_SUB_R    = 5'd6,
		K_MUL_M    = 5'd7,
		K_MUL_R    = 5'd8,
		K_DIV_M    = 5'd9,
		K_DIV_R    = 5'd10,
		K_CMP_M    = 5'd11,
		K_CMP_R    = 5'd12,
		K_LOAD     = 5'd13,
		K_MOVE     = 5'd14,
		K_STORE    = 5'd15,
		K_LOADADDR = 5'd16,
		K_JUMP     = 5'd17,
		K_JN       = 5'd18,
		K_JP       = 5'd19,
		K_JZ       = 5'd20
	} kind_t;

	localparam logic [1:0] FLAG_ZERO = 2'd0;
	localparam logic [1:0] FLAG_POS  = 2'd1;
	localparam logic [1:0] FLAG_NEG  = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_DIV0 = 2'd1;
	localparam logic [1:0] ERR_ADDR = 2'd2;

	// arithmetic unit operations
	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_CMP = 3'd4
	} alu_op_t;

	typedef struct packed {
		logic [4:0]         kind;
		logic [3:0]         target_reg;
		logic [3:0]         source_reg;
		logic [11:0]        byte_offset;
		logic [4:0]         index_sel;
		logic signed [31:0] immediate;
		logic [10:0]        fill_count;
		logic [15:0]        jump_target;
	} instr_t;

	typedef struct packed {
		logic [15:0]        next_index;
		logic               jump_taken;
		logic signed [31:0] written_value;
		logic [1:0]         flag;
		logic [1:0]         error;
	} result_t;

	// start/done bundle between sequencer and arithmetic unit
	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;

	typedef struct packed {
		logic        done;
		logic        div0;
		logic [31:0] res;
	} alu_sts_t;

	function automatic logic [1:0] flag_of(input logic [31:0] v);
		if (v == 32'd0) begin
			return FLAG_ZERO;
		end
		return v[31] ? FLAG_NEG : FLAG_POS;
	endfunction

endpackage

### hw/rtl/paeu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paeu_if: valid/ready channel
// Carries one payload of a generic type per transfer.
// ----------------------------------------------------------------------------
interface paeu_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/paeu_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paeu_alu: shared arithmetic unit
// Add/sub/compare from the idle state, multiply via 16x32 partial products
// (low half, then high half), signed divide by restoring division one bit a cycle.
// ----------------------------------------------------------------------------
module paeu_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  paeu_pkg::alu_ctl_t  ctl,
	input  logic [31:0]         a,
	input  logic [31:0]         b,
	output paeu_pkg::alu_sts_t  sts
);
	typedef enum logic [3:0] {
		A_IDLE = 4'b0001,
		A_MUL  = 4'b0010,
		A_DIV  = 4'b0100,
		A_DONE = 4'b1000
	} astate_t;

	astate_t     state_q;
	logic [31:0] acc_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] div_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic        neg_q;
	logic        div0_q;
	logic        isdiv_q;
	logic [4:0]  cnt_q;

	logic [31:0] ma;
	logic [31:0] mb;
	logic [32:0] trial;
	logic [31:0] rem_sh;
	logic [47:0] pp;

	assign ma     = a[31] ? (32'd0 - a) : a;
	assign mb     = b[31] ? (32'd0 - b) : b;
	assign rem_sh = {rem_q[30:0], quo_q[31]};
	assign trial  = {1'b0, rem_sh} - {1'b0, div_q};
	// multiply: low half of a times b first, then high half
	assign pp     = {16'd0, (cnt_q[0] ? a_q[31:16] : a_q[15:0])} * {16'd0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (ctl.start) begin
						case (ctl.op)
							paeu_pkg::OP_MUL: state_q <= A_MUL;
							paeu_pkg::OP_DIV: state_q <= (b == 32'd0) ? A_DONE : A_DIV;
							default:          state_q <= A_DONE;
						endcase
					end
				end
				A_MUL:   if (cnt_q[0]) state_q <= A_DONE;
				A_DIV:   if (cnt_q == 5'd31) state_q <= A_DONE;
				A_DONE:  state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				a_q     <= a;
				b_q     <= b;
				cnt_q   <= 5'd0;
				div0_q  <= (ctl.op == paeu_pkg::OP_DIV) && (b == 32'd0);
				isdiv_q <= (ctl.op == paeu_pkg::OP_DIV);
				rem_q   <= 32'd0;
				quo_q   <= ma;
				div_q   <= mb;
				neg_q   <= a[31] ^ b[31];
				case (ctl.op)
					paeu_pkg::OP_ADD:                   acc_q <= a + b;
					paeu_pkg::OP_MUL, paeu_pkg::OP_DIV: acc_q <= 32'd0;
					default:                            acc_q <= a - b;
				endcase
			end
			A_MUL: begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q[0]) begin
					acc_q <= acc_q + {pp[15:0], 16'd0};
				end else begin
					acc_q <= pp[31:0];
				end
			end
			A_DIV: begin
				cnt_q <= cnt_q + 5'd1;
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// quotient sign fixed at the output
	logic [31:0] quo_fix;
	assign quo_fix = neg_q ? (32'd0 - quo_q) : quo_q;

	assign sts.done = (state_q == A_DONE);
	assign sts.div0 = div0_q;
	assign sts.res  = isdiv_q ? quo_fix : acc_q;
endmodule

### hw/rtl/pseudo_asm_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pseudo_asm_execute_unit: instruction execute unit
// Executes one decoded instruction per transfer against a register file,
// a word data memory, a sign flag and a program index.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------
//  instr    | in  | kind, regs, offset, index, immediate, count, target
//  result   | out | next_index, jump_taken, written_value, flag, error
//
// From input transfer to result transfer: the address state, a memory read
// for memory forms, then execute and wait in the shared unit (one quotient
// bit a cycle for divide) for arithmetic or writeback for the rest, then the
// output register. A fill writes its words in turn (single memory port).
// Reset clears registers, flag and program index; memory is not cleared.
// The next instruction is taken the cycle after the result has left the
// output register; a stalled result stalls the input.
// ----------------------------------------------------------------------------
module pseudo_asm_execute_unit #(
	parameter int MEM_WORDS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	paeu_if.sink   instr,
	paeu_if.source result
);
	localparam int AW = $clog2(MEM_WORDS);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_ADDR  = 8'b00000010,
		S_MEMRD = 8'b00000100,
		S_EXEC  = 8'b00001000,
		S_WAIT  = 8'b00010000,
		S_FILL  = 8'b00100000,
		S_WB    = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t              state_q;
	paeu_pkg::instr_t    in_q;
	logic [31:0]         regs_q [16];
	logic [31:0]         mem [MEM_WORDS];
	logic [31:0]         rd_q;
	logic [1:0]          flag_q;
	logic [15:0]         pc_q;
	logic [AW-1:0]       waddr_q;
	logic                addr_ok_q;
	logic [10:0]         left_q;
	paeu_pkg::result_t   res_q;
	logic                ovalid_q;
	paeu_pkg::alu_ctl_t  actl;
	paeu_pkg::alu_sts_t  asts;
	logic [31:0]         alu_a;
	logic [31:0]         alu_b;

	logic [4:0]  k;
	logic        is_arith;
	logic        reg_form;
	logic [2:0]  opc;
	logic [31:0] ea;
	logic [31:0] idx_val;
	logic [12:0] fill_end;

	assign k        = in_q.kind;
	assign is_arith = (k >= paeu_pkg::K_ADD_M) && (k <= paeu_pkg::K_CMP_R);
	assign reg_form = ~k[0];
	assign opc      = 3'((k - 5'd3) >> 1);
	assign idx_val  = (in_q.index_sel == 5'd0) ? 32'd0 : regs_q[4'(in_q.index_sel - 5'd1)];
	assign ea       = {20'd0, in_q.byte_offset} + idx_val;
	assign fill_end = {3'd0, in_q.byte_offset[11:2]} + {2'd0, in_q.fill_count};

	assign alu_a    = regs_q[in_q.target_reg];
	assign alu_b    = reg_form ? regs_q[in_q.source_reg] : rd_q;
	assign actl.start = (state_q == S_EXEC);
	assign actl.op    = paeu_pkg::alu_op_t'(opc);

	paeu_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (actl),
		.a      (alu_a),
		.b      (alu_b),
		.sts    (asts)
	);

	assign instr.ready  = (state_q == S_IDLE) && !ovalid_q;
	assign result.valid = ovalid_q;
	assign result.data  = res_q;

	logic mem_form;
	assign mem_form = (is_arith && !reg_form) || k == paeu_pkg::K_LOAD ||
		k == paeu_pkg::K_STORE;

	// data memory port
	always_ff @(posedge clk) begin
		if (state_q == S_FILL && left_q != 11'd0) begin
			mem[waddr_q] <= (k == paeu_pkg::K_CONST) ? in_q.immediate : 32'd0;
		end else if (state_q == S_WB && k == paeu_pkg::K_STORE && addr_ok_q) begin
			mem[waddr_q] <= regs_q[in_q.target_reg];
		end
		rd_q <= mem[waddr_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			flag_q   <= paeu_pkg::FLAG_ZERO;
			pc_q     <= 16'd0;
			for (int i = 0; i < 16; i++) begin
				regs_q[i] <= 32'd0;
			end
		end else begin
			if (result.valid && result.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (instr.valid && instr.ready) begin
						in_q    <= instr.data;
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					res_q.next_index <= pc_q + 16'd1;
					res_q.jump_taken <= 1'b0;
					if (k == paeu_pkg::K_STORAGE || k == paeu_pkg::K_CONST) begin
						waddr_q <= AW'(in_q.byte_offset[11:2]);
						left_q  <= in_q.fill_count;
						if (32'(fill_end) > 32'(MEM_WORDS)) begin
							res_q.written_value <= 32'sd0;
							res_q.error         <= paeu_pkg::ERR_ADDR;
							state_q             <= S_OUT;
						end else begin
							res_q.written_value <= (k == paeu_pkg::K_CONST &&
								in_q.fill_count != 11'd0) ? in_q.immediate : 32'sd0;
							res_q.error         <= paeu_pkg::ERR_NONE;
							state_q             <= S_FILL;
						end
					end else if (mem_form) begin
						res_q.written_value <= 32'sd0;
						waddr_q   <= AW'(ea[31:2]);
						addr_ok_q <= ({2'd0, ea[31:2]} < 32'(MEM_WORDS));
						if (({2'd0, ea[31:2]} < 32'(MEM_WORDS))) begin
							res_q.error <= paeu_pkg::ERR_NONE;
							state_q     <= S_MEMRD;
						end else begin
							res_q.error <= paeu_pkg::ERR_ADDR;
							state_q     <= S_OUT;
						end
					end else begin
						res_q.written_value <= 32'sd0;
						res_q.error         <= paeu_pkg::ERR_NONE;
						state_q             <= is_arith ? S_EXEC : S_WB;
					end
				end
				S_MEMRD: state_q <= is_arith ? S_EXEC : S_WB;
				S_EXEC:  state_q <= S_WAIT;
				S_WAIT: begin
					if (asts.done) begin
						if (opc == 3'(paeu_pkg::OP_DIV) && asts.div0) begin
							res_q.error <= paeu_pkg::ERR_DIV0;
						end else begin
							flag_q <= paeu_pkg::flag_of(asts.res);
							if (opc != 3'(paeu_pkg::OP_CMP)) begin
								regs_q[in_q.target_reg] <= asts.res;
								res_q.written_value     <= asts.res;
							end
						end
						state_q <= S_OUT;
					end
				end
				S_FILL: begin
					if (left_q == 11'd0) begin
						state_q <= S_OUT;
					end else begin
						left_q  <= left_q - 11'd1;
						waddr_q <= waddr_q + AW'(1);
					end
				end
				S_WB: begin
					case (k)
						paeu_pkg::K_LOAD: begin
							regs_q[in_q.target_reg] <= rd_q;
							res_q.written_value     <= rd_q;
						end
						paeu_pkg::K_MOVE: begin
							regs_q[in_q.target_reg] <= regs_q[in_q.source_reg];
							res_q.written_value     <= regs_q[in_q.source_reg];
						end
						paeu_pkg::K_STORE: res_q.written_value <= regs_q[in_q.target_reg];
						paeu_pkg::K_LOADADDR: begin
							regs_q[in_q.target_reg] <= in_q.immediate;
							res_q.written_value     <= in_q.immediate;
						end
						paeu_pkg::K_JUMP, paeu_pkg::K_JN, paeu_pkg::K_JP, paeu_pkg::K_JZ: begin
							if (k == paeu_pkg::K_JUMP ||
								(k == paeu_pkg::K_JN && flag_q == paeu_pkg::FLAG_NEG) ||
								(k == paeu_pkg::K_JP && flag_q == paeu_pkg::FLAG_POS) ||
								(k == paeu_pkg::K_JZ && flag_q == paeu_pkg::FLAG_ZERO)) begin
								res_q.jump_taken <= 1'b1;
								res_q.next_index <= in_q.jump_target;
							end
						end
						default: ;
					endcase
					state_q <= S_OUT;
				end
				S_OUT: begin
					res_q.flag <= flag_q;
					pc_q       <= res_q.next_index;
					ovalid_q   <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/paeu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paeu_checker: port-level checks of the execute unit
// No intake while a result is pending; error and hold rules on the result.
// ----------------------------------------------------------------------------
module paeu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input paeu_pkg::result_t out_data
);
	// no intake while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("intake while result pending");

	// an accepted instruction never gives a result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");

	// a result with an error never has a jump taken
	a_err_nojump: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.error != paeu_pkg::ERR_NONE) |-> !out_data.jump_taken)
		else $error("jump with error");

	// error results write nothing
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.error != paeu_pkg::ERR_NONE) |-> out_data.written_value == 0)
		else $error("error result carries value");

	// result holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data)) else $error("result changed");
endmodule

bind pseudo_asm_execute_unit paeu_checker u_paeu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (instr.valid),
	.in_ready  (instr.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);
